[rtl/fmp_pkg.sv]
// Shared types, constants and the microcode program of the Fibonacci matrix-power core.
package fmp_pkg;

    localparam int FMP_INDEX_BITS = 63;
    localparam int FIB_W          = 30;

    localparam logic [31:0] FIB_MOD    = 32'd1000000007;
    localparam logic [31:0] FIB_MOD_X2 = 32'd2000000014;
    localparam logic [31:0] FIB_MOD_X3 = 32'd3000000021;
    localparam logic [63:0] MU_WIDE    = (64'd1 << 60) / 64'd1000000007;
    localparam logic [31:0] BARRETT_MU = MU_WIDE[31:0];

    localparam int RF_DEPTH = 16;
    localparam int RF_AW    = 4;
    localparam int ACC_BASE = 0;
    localparam int PW_BASE  = 4;
    localparam int TMP_BASE = 8;

    localparam logic [7:0] INIT_PATTERN = 8'b0111_1001;

    localparam int ENTRY_STEPS = 8;
    localparam int COPY_STEPS  = 5;
    localparam int BLK_LEN     = 4 * ENTRY_STEPS + COPY_STEPS;

    localparam int A_IDLE  = 0;
    localparam int A_INIT  = 1;
    localparam int A_TEST  = A_INIT + 8;
    localparam int A_MULB  = A_TEST + 1;
    localparam int A_SQCHK = A_MULB + BLK_LEN;
    localparam int A_SQB   = A_SQCHK + 1;
    localparam int A_SHIFT = A_SQB + BLK_LEN;
    localparam int A_FIN   = A_SHIFT + 1;
    localparam int A_OUT   = A_FIN + 1;
    localparam int UPC_W   = 7;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_JZ_BIT,
        SEQ_JZ_UPPER,
        SEQ_JMP,
        SEQ_OUT
    } seq_op_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_RF,
        MUL_Q1,
        MUL_Q2
    } mul_op_t;

    typedef enum logic [1:0] {
        X_NONE,
        X_LOAD,
        X_ADD
    } x_op_t;

    typedef enum logic [1:0] {
        W_ZERO,
        W_ONE,
        W_FIX,
        W_RD
    } wsrc_t;

    typedef struct packed {
        seq_op_t            seq;
        logic [UPC_W-1:0]   target;
        logic               n_shift;
        logic               rd_en;
        logic [RF_AW-1:0]   ra;
        logic [RF_AW-1:0]   rb;
        mul_op_t            mul;
        x_op_t              xop;
        logic               r_load;
        logic               wr_en;
        logic [RF_AW-1:0]   wa;
        wsrc_t              wsrc;
        logic               out_load;
    } ucode_t;

    // One step of a 2x2 product block: four entries into tmp, then copy tmp to dst.
    function automatic ucode_t fmp_blk_step(input int off, input int xb, input int yb,
                                            input int db);
        ucode_t w;
        int     e;
        int     k;
        int     i;
        int     j;
        int     c;
        w = '0;
        e = off / ENTRY_STEPS;
        k = off % ENTRY_STEPS;
        i = e / 2;
        j = e % 2;
        c = off - 4 * ENTRY_STEPS;
        if (off < 4 * ENTRY_STEPS) begin
            unique case (k)
                0: begin
                    w.rd_en = 1'b1;
                    w.ra    = RF_AW'(xb + 2 * i);
                    w.rb    = RF_AW'(yb + j);
                end
                1: begin
                    w.mul   = MUL_RF;
                    w.rd_en = 1'b1;
                    w.ra    = RF_AW'(xb + 2 * i + 1);
                    w.rb    = RF_AW'(yb + 2 + j);
                end
                2: begin
                    w.mul = MUL_RF;
                    w.xop = X_LOAD;
                end
                3: w.xop = X_ADD;
                4: w.mul = MUL_Q1;
                5: w.mul = MUL_Q2;
                6: w.r_load = 1'b1;
                7: begin
                    w.wr_en = 1'b1;
                    w.wa    = RF_AW'(TMP_BASE + e);
                    w.wsrc  = W_FIX;
                end
                default: w.seq = SEQ_NEXT;
            endcase
        end else begin
            if (c < 4) begin
                w.rd_en = 1'b1;
                w.ra    = RF_AW'(TMP_BASE + c);
            end
            if (c > 0) begin
                w.wr_en = 1'b1;
                w.wa    = RF_AW'(db + c - 1);
                w.wsrc  = W_RD;
            end
        end
        return w;
    endfunction

    // Microcode ROM.
    function automatic ucode_t fmp_ucode(input logic [UPC_W-1:0] addr);
        ucode_t w;
        int     a;
        w = '0;
        a = int'(addr);
        if (a == A_IDLE) begin
            w.seq = SEQ_WAIT_IN;
        end else if (a >= A_INIT && a < A_TEST) begin
            w.wr_en = 1'b1;
            w.wa    = RF_AW'(a - A_INIT);
            w.wsrc  = INIT_PATTERN[a - A_INIT] ? W_ONE : W_ZERO;
        end else if (a == A_TEST) begin
            w.seq    = SEQ_JZ_BIT;
            w.target = UPC_W'(A_SQCHK);
        end else if (a >= A_MULB && a < A_SQCHK) begin
            w = fmp_blk_step(a - A_MULB, ACC_BASE, PW_BASE, ACC_BASE);
        end else if (a == A_SQCHK) begin
            w.seq    = SEQ_JZ_UPPER;
            w.target = UPC_W'(A_FIN);
        end else if (a >= A_SQB && a < A_SHIFT) begin
            w = fmp_blk_step(a - A_SQB, PW_BASE, PW_BASE, PW_BASE);
        end else if (a == A_SHIFT) begin
            w.seq     = SEQ_JMP;
            w.target  = UPC_W'(A_TEST);
            w.n_shift = 1'b1;
        end else if (a == A_FIN) begin
            w.rd_en = 1'b1;
            w.ra    = RF_AW'(ACC_BASE);
        end else if (a == A_OUT) begin
            w.seq      = SEQ_OUT;
            w.target   = UPC_W'(A_IDLE);
            w.out_load = 1'b1;
        end else begin
            w.seq    = SEQ_JMP;
            w.target = UPC_W'(A_IDLE);
        end
        return w;
    endfunction

endpackage

[rtl/fib_mod_matrix_power_core.sv]
// Top level of the Fibonacci matrix-power core, F(n+1) mod 1000000007.
//
// Takes an index n on the slave stream and returns F(n+1) mod 1000000007 on the
// master stream, one result per transfer, n = 0 giving 1. One item is worked at a
// time; a finished result sits in the output register so the next index can be
// taken while it waits. The work runs as a microcode program over a small matrix
// register file and one shared 32x32 multiplier with Barrett reduction; each matrix
// product entry is two products summed, reduced and written to a temporary, and a
// full 2x2 product then copies its four temporaries back. Each bit of n below the
// highest set bit costs one squaring and each set bit one further product; scanning
// stops at the highest set bit.
module fib_mod_matrix_power_core
    import fmp_pkg::*;
#(
    parameter int INDEX_BITS = FMP_INDEX_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((INDEX_BITS+7)/8)*8-1:0]     s_tdata,    // index_n
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata     // fib_value
);

    ucode_t           ctrl;
    logic [FIB_W-1:0] fib_value;

    fmp_sequencer #(
        .INDEX_BITS (INDEX_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_index  (s_tdata[INDEX_BITS-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctrl      (ctrl)
    );

    fmp_datapath u_dp (
        .clk       (clk),
        .ctrl      (ctrl),
        .fib_value (fib_value)
    );

    assign m_tdata = {2'b00, fib_value};

endmodule

[rtl/fmp_sequencer.sv]
// Microcode sequencer: step counter, index shift register and stream handshakes.
module fmp_sequencer
    import fmp_pkg::*;
#(
    parameter int INDEX_BITS = FMP_INDEX_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INDEX_BITS-1:0] in_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ucode_t                ctrl
);

    logic [UPC_W-1:0]      upc_reg;
    logic [UPC_W-1:0]      upc_next;
    logic [INDEX_BITS-1:0] n_reg;
    logic [INDEX_BITS-1:0] n_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_fire;
    ucode_t                word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UPC_W'(A_IDLE);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
    end

    always_comb
    begin
        word     = fmp_ucode(upc_reg);
        upc_next = upc_reg;
        n_next   = n_reg;
        in_ready = 1'b0;
        out_fire = 1'b0;
        unique case (word.seq)
            SEQ_NEXT:
                upc_next = upc_reg + 1'b1;
            SEQ_WAIT_IN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    upc_next = upc_reg + 1'b1;
                    n_next   = in_index;
                end
            end
            SEQ_JZ_BIT:
                upc_next = n_reg[0] ? upc_reg + 1'b1 : word.target;
            SEQ_JZ_UPPER:
                upc_next = ((n_reg >> 1) == '0) ? word.target : upc_reg + 1'b1;
            SEQ_JMP:
                upc_next = word.target;
            SEQ_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_fire = 1'b1;
                    upc_next = word.target;
                end
            end
            default:
                upc_next = UPC_W'(A_IDLE);
        endcase
        if (word.n_shift)
        begin
            n_next = n_reg >> 1;
        end
        out_valid_next = out_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        ctrl           = word;
        ctrl.out_load  = word.out_load & out_fire;
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/fmp_datapath.sv]
// Datapath: matrix register file, shared multiplier, Barrett reduction and output register.
module fmp_datapath
    import fmp_pkg::*;
(
    input  logic             clk,
    input  ucode_t           ctrl,
    output logic [FIB_W-1:0] fib_value
);

    logic [FIB_W-1:0] rf_mem [RF_DEPTH];
    logic [FIB_W-1:0] rd_a_reg;
    logic [FIB_W-1:0] rd_b_reg;
    logic [63:0]      prod_reg;
    logic [60:0]      x_reg;
    logic [31:0]      r_reg;
    logic [FIB_W-1:0] out_data_reg;

    logic [31:0]      opa;
    logic [31:0]      opb;
    logic [63:0]      mul_out;
    logic [31:0]      r_fix;
    logic [FIB_W-1:0] wdata;

    always_comb
    begin
        unique case (ctrl.mul)
            MUL_RF:
            begin
                opa = {2'b00, rd_a_reg};
                opb = {2'b00, rd_b_reg};
            end
            MUL_Q1:
            begin
                opa = x_reg[60:29];
                opb = BARRETT_MU;
            end
            MUL_Q2:
            begin
                opa = prod_reg[62:31];
                opb = FIB_MOD;
            end
            MUL_NONE:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign mul_out = opa * opb;

    // residue below 4p after Barrett; one step brings it below p
    always_comb
    begin
        priority if (r_reg >= FIB_MOD_X3)
            r_fix = r_reg - FIB_MOD_X3;
        else if (r_reg >= FIB_MOD_X2)
            r_fix = r_reg - FIB_MOD_X2;
        else if (r_reg >= FIB_MOD)
            r_fix = r_reg - FIB_MOD;
        else
            r_fix = r_reg;
    end

    always_comb
    begin
        unique case (ctrl.wsrc)
            W_ZERO: wdata = '0;
            W_ONE:  wdata = FIB_W'(1);
            W_FIX:  wdata = r_fix[FIB_W-1:0];
            W_RD:   wdata = rd_a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            rf_mem[ctrl.wa] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rd_a_reg <= rf_mem[ctrl.ra];
            rd_b_reg <= rf_mem[ctrl.rb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul != MUL_NONE)
        begin
            prod_reg <= mul_out;
        end
        unique case (ctrl.xop)
            X_LOAD:  x_reg <= {1'b0, prod_reg[59:0]};
            X_ADD:   x_reg <= x_reg + {1'b0, prod_reg[59:0]};
            default: x_reg <= x_reg;
        endcase
        if (ctrl.r_load)
        begin
            r_reg <= x_reg[31:0] - prod_reg[31:0];
        end
        if (ctrl.out_load)
        begin
            out_data_reg <= rd_a_reg;
        end
    end

    assign fib_value = out_data_reg;

endmodule

[rtl/fmp_checker.sv]
// Port-level checker for the Fibonacci matrix-power core, with its bind.
module fmp_checker
    import fmp_pkg::*;
#(
    parameter int INDEX_BITS = FMP_INDEX_BITS
)
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [((INDEX_BITS+7)/8)*8-1:0] s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [31:0]                     m_tdata
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("index changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata < FIB_MOD)
        else $error("result not reduced");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second index taken while busy");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("not ready for next index after result");

endmodule

bind fib_mod_matrix_power_core fmp_checker #(.INDEX_BITS(INDEX_BITS)) u_fmp_checker (.*);
